[rtl/core/antialiased_pixel_blend_macros.svh]
// Assertion macros for the antialiased pixel blend checker
`ifndef ANTIALIASED_PIXEL_BLEND_MACROS_SVH
`define ANTIALIASED_PIXEL_BLEND_MACROS_SVH

// property must hold on every clock edge out of reset
`define AAB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// expression must never be true out of reset
`define AAB_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

[rtl/core/aab_pkg.sv]
// Shared types, codes and helpers for the antialiased pixel blend
`timescale 1ns / 1ps
package aab_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned SumW   = 11;
  localparam int unsigned CountW = 4;
  localparam int unsigned NumChan = 3;
  localparam int unsigned QShift = 8;
  localparam int unsigned BrightW = 9;
  localparam int unsigned ProdW  = ChanW + BrightW;
  localparam int unsigned StepW  = 3;
  localparam int unsigned RemW   = 3;

  localparam logic [CountW-1:0]  CountMax   = 4'd8;
  localparam logic [BrightW-1:0] BrightFull = 9'd256;
  localparam logic [StepW-1:0]   StepLast   = 3'd7;

  // neighbour direction codes
  localparam logic [2:0] DirE  = 3'd0;
  localparam logic [2:0] DirSE = 3'd1;
  localparam logic [2:0] DirS  = 3'd2;
  localparam logic [2:0] DirSW = 3'd3;
  localparam logic [2:0] DirW  = 3'd4;
  localparam logic [2:0] DirNW = 3'd5;
  localparam logic [2:0] DirN  = 3'd6;
  localparam logic [2:0] DirNE = 3'd7;

  // pixel format field positions
  localparam int unsigned RShiftLsb = 0;
  localparam int unsigned RSizeLsb  = 5;
  localparam int unsigned GShiftLsb = 9;
  localparam int unsigned GSizeLsb  = 14;
  localparam int unsigned BShiftLsb = 18;
  localparam int unsigned BSizeLsb  = 23;
  localparam int unsigned ShiftW    = 5;
  localparam int unsigned SizeW     = 4;

  localparam logic [26:0] PixelFormatRst  = 27'd67244304;
  localparam logic [12:0] ScreenWidthRst  = 13'd640;
  localparam logic [12:0] ScreenHeightRst = 13'd480;
  localparam logic [31:0] BackgroundRst   = 32'd0;

  typedef enum logic [1:0] {
    CfgPixelFormat,
    CfgScreenWidth,
    CfgScreenHeight,
    CfgBackground
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StMul,
    StFin
  } state_e;

  typedef struct packed {
    logic acc;
    logic close;
    logic div_step;
    logic mul;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic close_item;
    logic div_last;
  } status_t;

  function automatic logic [ChanW-1:0] chan_get(input logic [31:0] colour,
                                                input logic [ShiftW-1:0] sh,
                                                input logic [SizeW-1:0] sz);
    logic [31:0]      shifted;
    logic [ChanW-1:0] res;
    shifted = colour >> sh;
    for (int i = 0; i < ChanW; i++) begin
      res[i] = shifted[i] & (SizeW'(i) < sz);
    end
    return res;
  endfunction

endpackage

[rtl/core/aab_ctrl.sv]
// Controller state machine for the antialiased pixel blend
`timescale 1ns / 1ps
module aab_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  aab_pkg::status_t status_i,
  output aab_pkg::cmd_t   cmd_o,
  output logic            busy_o
);

  aab_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aab_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      aab_pkg::StIdle: begin
        if (start_i && status_i.close_item) begin
          state_d = aab_pkg::StDiv;
        end
      end
      aab_pkg::StDiv: begin
        if (status_i.div_last) begin
          state_d = aab_pkg::StMul;
        end
      end
      aab_pkg::StMul: state_d = aab_pkg::StFin;
      aab_pkg::StFin: state_d = aab_pkg::StIdle;
      default:        state_d = aab_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      aab_pkg::StIdle: begin
        busy_o       = 1'b0;
        cmd_o.acc    = start_i;
        cmd_o.close  = start_i & status_i.close_item;
      end
      aab_pkg::StDiv: cmd_o.div_step = 1'b1;
      aab_pkg::StMul: cmd_o.mul = 1'b1;
      aab_pkg::StFin: cmd_o.fin = 1'b1;
      default:        busy_o = 1'b1;
    endcase
  end

endmodule

[rtl/core/aab_datapath.sv]
// Datapath: neighbour sums, per-channel divider lanes, blend and packing
`timescale 1ns / 1ps
module aab_datapath #(
  parameter int unsigned CoordBits = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  aab_pkg::cmd_t        cmd_i,
  output aab_pkg::status_t     status_o,
  input  logic [26:0]          pixel_format_i,
  input  logic [12:0]          screen_width_i,
  input  logic [12:0]          screen_height_i,
  input  logic [31:0]          background_color_i,
  input  logic [CoordBits-1:0] pos_x_i,
  input  logic [CoordBits-1:0] pos_y_i,
  input  logic [31:0]          fore_color_i,
  input  logic [8:0]           brightness_i,
  input  logic [2:0]           direction_i,
  input  logic                 neighbor_enabled_i,
  input  logic [31:0]          neighbor_value_i,
  output logic [CoordBits-1:0] out_x_o,
  output logic [CoordBits-1:0] out_y_o,
  output logic [31:0]          blended_color_o,
  output logic                 done_o
);

  localparam int unsigned ExtW = (CoordBits + 1 > 13) ? CoordBits + 1 : 13;
  localparam int unsigned NC   = aab_pkg::NumChan;
  localparam int unsigned CW   = aab_pkg::ChanW;

  logic [aab_pkg::ShiftW-1:0] sh [NC];
  logic [aab_pkg::SizeW-1:0]  sz [NC];

  assign sh[0] = pixel_format_i[aab_pkg::RShiftLsb +: aab_pkg::ShiftW];
  assign sh[1] = pixel_format_i[aab_pkg::GShiftLsb +: aab_pkg::ShiftW];
  assign sh[2] = pixel_format_i[aab_pkg::BShiftLsb +: aab_pkg::ShiftW];
  assign sz[0] = pixel_format_i[aab_pkg::RSizeLsb +: aab_pkg::SizeW];
  assign sz[1] = pixel_format_i[aab_pkg::GSizeLsb +: aab_pkg::SizeW];
  assign sz[2] = pixel_format_i[aab_pkg::BSizeLsb +: aab_pkg::SizeW];

  // neighbour bounds
  logic east, south, west, north, in_bounds, hit;

  assign east  = (ExtW'(pos_x_i) + ExtW'(1)) < ExtW'(screen_width_i);
  assign south = (ExtW'(pos_y_i) + ExtW'(1)) < ExtW'(screen_height_i);
  assign west  = pos_x_i != '0;
  assign north = pos_y_i != '0;

  always_comb begin
    unique case (direction_i)
      aab_pkg::DirE:  in_bounds = east;
      aab_pkg::DirSE: in_bounds = east & south;
      aab_pkg::DirS:  in_bounds = south;
      aab_pkg::DirSW: in_bounds = west & south;
      aab_pkg::DirW:  in_bounds = west;
      aab_pkg::DirNW: in_bounds = west & north;
      aab_pkg::DirN:  in_bounds = north;
      aab_pkg::DirNE: in_bounds = east & north;
      default:        in_bounds = 1'b0;
    endcase
  end

  logic [aab_pkg::CountW-1:0] cnt_q, cnt_d, cnt_new;
  logic [aab_pkg::SumW-1:0]   sum_q [NC];
  logic [aab_pkg::SumW-1:0]   sum_d [NC];
  logic [aab_pkg::SumW-1:0]   sum_new [NC];

  assign hit = neighbor_enabled_i & in_bounds & (neighbor_value_i != fore_color_i)
             & (cnt_q < aab_pkg::CountMax);
  assign cnt_new = hit ? cnt_q + 4'd1 : cnt_q;

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      sum_new[c] = sum_q[c]
                 + (hit ? aab_pkg::SumW'(aab_pkg::chan_get(neighbor_value_i, sh[c], sz[c]))
                        : '0);
      sum_d[c] = sum_q[c];
      if (cmd_i.acc) begin
        sum_d[c] = cmd_i.close ? '0 : sum_new[c];
      end
    end
    cnt_d = cnt_q;
    if (cmd_i.acc) begin
      cnt_d = cmd_i.close ? '0 : cnt_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int c = 0; c < NC; c++) begin
        sum_q[c] <= '0;
      end
    end else begin
      cnt_q <= cnt_d;
      for (int c = 0; c < NC; c++) begin
        sum_q[c] <= sum_d[c];
      end
    end
  end

  // closing operands and divider lanes
  logic [CoordBits-1:0]        x_q, y_q;
  logic [31:0]                 fg_q;
  logic [aab_pkg::BrightW-1:0] b_q;
  logic [aab_pkg::CountW-1:0]  divisor_q;
  logic [aab_pkg::StepW-1:0]   step_q;
  logic [aab_pkg::RemW-1:0]    rem_q [NC];
  logic [CW-1:0]               dvd_q [NC];
  logic [aab_pkg::CountW-1:0]  trial [NC];
  logic                        ge [NC];

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      trial[c] = {rem_q[c], dvd_q[c][CW-1]};
      ge[c]    = trial[c] >= divisor_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.close) begin
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      step_q <= step_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.close) begin
      x_q       <= pos_x_i;
      y_q       <= pos_y_i;
      fg_q      <= fore_color_i;
      b_q       <= (brightness_i > aab_pkg::BrightFull) ? aab_pkg::BrightFull
                                                        : brightness_i;
      divisor_q <= cnt_new;
      for (int c = 0; c < NC; c++) begin
        rem_q[c] <= sum_new[c][aab_pkg::SumW-1:CW];
        dvd_q[c] <= sum_new[c][CW-1:0];
      end
    end else if (cmd_i.div_step) begin
      for (int c = 0; c < NC; c++) begin
        rem_q[c] <= ge[c] ? aab_pkg::RemW'(trial[c] - divisor_q)
                          : trial[c][aab_pkg::RemW-1:0];
        dvd_q[c] <= {dvd_q[c][CW-2:0], ge[c]};
      end
    end
  end

  assign status_o.close_item = direction_i == aab_pkg::DirNE;
  assign status_o.div_last   = step_q == aab_pkg::StepLast;

  // blend
  logic [CW-1:0]              avg [NC];
  logic [CW-1:0]              fgc [NC];
  logic [CW-1:0]              avg_q [NC];
  logic                       gt_q [NC];
  logic [aab_pkg::ProdW-1:0]  prod_q [NC];
  logic [aab_pkg::ProdW-1:0]  rnd [NC];
  logic [CW-1:0]              res [NC];
  logic [31:0]                packed_color;

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      avg[c] = (divisor_q == '0) ? aab_pkg::chan_get(background_color_i, sh[c], sz[c])
                                 : dvd_q[c];
      fgc[c] = aab_pkg::chan_get(fg_q, sh[c], sz[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      for (int c = 0; c < NC; c++) begin
        avg_q[c]  <= avg[c];
        gt_q[c]   <= fgc[c] > avg[c];
        prod_q[c] <= (fgc[c] > avg[c])
                   ? aab_pkg::ProdW'(fgc[c] - avg[c]) * aab_pkg::ProdW'(b_q)
                   : aab_pkg::ProdW'(avg[c] - fgc[c]) * aab_pkg::ProdW'(b_q);
      end
    end
  end

  always_comb begin
    packed_color = '0;
    for (int c = 0; c < NC; c++) begin
      rnd[c] = prod_q[c] + aab_pkg::ProdW'((1 << aab_pkg::QShift) - 1);
      res[c] = gt_q[c] ? avg_q[c] + prod_q[c][aab_pkg::QShift +: CW]
                       : avg_q[c] - rnd[c][aab_pkg::QShift +: CW];
      packed_color = packed_color | (32'(res[c]) << sh[c]);
    end
  end

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      blended_color_o <= packed_color;
      out_x_o         <= x_q;
      out_y_o         <= y_q;
    end
  end

  assign done_o = done_q;

endmodule

[rtl/core/antialiased_pixel_blend.sv]
// Top level of the antialiased pixel blend: configuration registers and core
`timescale 1ns / 1ps
// An item is taken whenever start is high and busy is low. Items whose
// direction is not NE are taken without raising busy, so they may follow
// back to back. The NE item closes the blend: busy then stays high while
// three parallel restoring divider lanes form one average bit per cycle,
// then through the blend multiply and then through the add and pack. The
// result is on out_x_o, out_y_o and blended_color_o for exactly one cycle
// with done_o, as busy falls, and must be taken then. Configuration writes
// are always ready and take effect from the next cycle.
module antialiased_pixel_blend #(
  parameter int unsigned CoordBits = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [CoordBits-1:0] pos_x_i,
  input  logic [CoordBits-1:0] pos_y_i,
  input  logic [31:0]          fore_color_i,
  input  logic [8:0]           brightness_i,
  input  logic [2:0]           direction_i,
  input  logic                 neighbor_enabled_i,
  input  logic [31:0]          neighbor_value_i,
  output logic [CoordBits-1:0] out_x_o,
  output logic [CoordBits-1:0] out_y_o,
  output logic [31:0]          blended_color_o,
  output logic                 done_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  logic [26:0] pixel_format_q;
  logic [12:0] screen_width_q;
  logic [12:0] screen_height_q;
  logic [31:0] background_color_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_format_q     <= aab_pkg::PixelFormatRst;
      screen_width_q     <= aab_pkg::ScreenWidthRst;
      screen_height_q    <= aab_pkg::ScreenHeightRst;
      background_color_q <= aab_pkg::BackgroundRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (aab_pkg::cfg_reg_e'(cfg_index_i))
        aab_pkg::CfgPixelFormat:  pixel_format_q     <= cfg_data_i[26:0];
        aab_pkg::CfgScreenWidth:  screen_width_q     <= cfg_data_i[12:0];
        aab_pkg::CfgScreenHeight: screen_height_q    <= cfg_data_i[12:0];
        aab_pkg::CfgBackground:   background_color_q <= cfg_data_i;
        default:                  background_color_q <= background_color_q;
      endcase
    end
  end

  aab_pkg::cmd_t    cmd;
  aab_pkg::status_t status;

  aab_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  aab_datapath #(
    .CoordBits (CoordBits)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .pixel_format_i     (pixel_format_q),
    .screen_width_i     (screen_width_q),
    .screen_height_i    (screen_height_q),
    .background_color_i (background_color_q),
    .pos_x_i            (pos_x_i),
    .pos_y_i            (pos_y_i),
    .fore_color_i       (fore_color_i),
    .brightness_i       (brightness_i),
    .direction_i        (direction_i),
    .neighbor_enabled_i (neighbor_enabled_i),
    .neighbor_value_i   (neighbor_value_i),
    .out_x_o            (out_x_o),
    .out_y_o            (out_y_o),
    .blended_color_o    (blended_color_o),
    .done_o             (done_o)
  );

endmodule

[rtl/core/aab_checker.sv]
// Port-level checker for the antialiased pixel blend, bound to the top level
`timescale 1ns / 1ps
`include "antialiased_pixel_blend_macros.svh"
module aab_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [2:0] direction_i,
  input logic       done_o
);

  `AAB_ASSERT(a_done_single, done_o |=> !done_o, "result strobe held for more than one cycle")
  `AAB_ASSERT_NEVER(a_done_idle, done_o && busy, "result strobe while busy")
  `AAB_ASSERT(a_plain_item, (start && !busy && direction_i != aab_pkg::DirNE) |=> !busy, "non-closing transfer raised busy")
  `AAB_ASSERT(a_close_item, (start && !busy && direction_i == aab_pkg::DirNE) |=> busy, "closing transfer did not raise busy")
  `AAB_ASSERT(a_result_latency, $rose(busy) |-> ##10 done_o, "result not given ten cycles after busy rose")

endmodule

bind antialiased_pixel_blend aab_checker u_aab_checker (.*);

[dv/antialiased_pixel_blend_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the antialiased pixel blend: directed and random blends
module antialiased_pixel_blend_tb;
  import aab_pkg::*;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [31:0] colour;
  } pixel_t;

  class blend_scoreboard;
    logic [26:0]       fmt;
    logic [12:0]       width;
    logic [12:0]       height;
    logic [31:0]       bg;
    logic [SumW-1:0]   sum_r;
    logic [SumW-1:0]   sum_g;
    logic [SumW-1:0]   sum_b;
    logic [CountW-1:0] count;
    pixel_t            pending[$];
    int unsigned       items;
    int unsigned       blends;
    int unsigned       results;
    int unsigned       mismatches;

    function new();
      fmt        = PixelFormatRst;
      width      = ScreenWidthRst;
      height     = ScreenHeightRst;
      bg         = BackgroundRst;
      sum_r      = '0;
      sum_g      = '0;
      sum_b      = '0;
      count      = '0;
      items      = 0;
      blends     = 0;
      results    = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (cfg_reg_e'(idx))
        CfgPixelFormat:  fmt = data[26:0];
        CfgScreenWidth:  width = data[12:0];
        CfgScreenHeight: height = data[12:0];
        CfgBackground:   bg = data;
        default: ;
      endcase
    endfunction

    function logic [7:0] channel(logic [31:0] colour, int sh_lsb, int sz_lsb);
      logic [31:0] mask;
      mask = (32'd1 << fmt[sz_lsb +: SizeW]) - 32'd1;
      return 8'((colour >> fmt[sh_lsb +: ShiftW]) & mask);
    endfunction

    function logic [7:0] blend_channel(logic [7:0] avg, logic [7:0] fg, logic [8:0] b);
      int unsigned prod;
      if (fg > avg) begin
        prod = (fg - avg) * b;
        return avg + 8'(prod >> QShift);
      end
      prod = (avg - fg) * b;
      return avg - 8'((prod + (1 << QShift) - 1) >> QShift);
    endfunction

    function bit on_screen(logic [11:0] x, logic [11:0] y, logic [2:0] dir);
      bit east;
      bit south;
      bit west;
      bit north;
      east  = (32'(x) + 1) < 32'(width);
      south = (32'(y) + 1) < 32'(height);
      west  = x != '0;
      north = y != '0;
      case (dir)
        DirE:    return east;
        DirSE:   return east && south;
        DirS:    return south;
        DirSW:   return west && south;
        DirW:    return west;
        DirNW:   return west && north;
        DirN:    return north;
        default: return east && north;
      endcase
    endfunction

    function void take_neighbour(logic [11:0] x, logic [11:0] y, logic [31:0] fg,
                                 logic [8:0] b, logic [2:0] dir, logic en,
                                 logic [31:0] nb);
      logic [7:0] ar;
      logic [7:0] ag;
      logic [7:0] ab;
      logic [8:0] bc;
      pixel_t     px;
      items++;
      if (en && on_screen(x, y, dir) && nb != fg && count < CountMax) begin
        sum_r += channel(nb, RShiftLsb, RSizeLsb);
        sum_g += channel(nb, GShiftLsb, GSizeLsb);
        sum_b += channel(nb, BShiftLsb, BSizeLsb);
        count++;
      end
      if (dir != DirNE) return;
      if (count != '0) begin
        ar = 8'(sum_r / count);
        ag = 8'(sum_g / count);
        ab = 8'(sum_b / count);
      end else begin
        ar = channel(bg, RShiftLsb, RSizeLsb);
        ag = channel(bg, GShiftLsb, GSizeLsb);
        ab = channel(bg, BShiftLsb, BSizeLsb);
      end
      bc = (b > BrightFull) ? BrightFull : b;
      px.x = x;
      px.y = y;
      px.colour = (32'(blend_channel(ar, channel(fg, RShiftLsb, RSizeLsb), bc))
                    << fmt[RShiftLsb +: ShiftW])
                | (32'(blend_channel(ag, channel(fg, GShiftLsb, GSizeLsb), bc))
                    << fmt[GShiftLsb +: ShiftW])
                | (32'(blend_channel(ab, channel(fg, BShiftLsb, BSizeLsb), bc))
                    << fmt[BShiftLsb +: ShiftW]);
      pending.push_back(px);
      sum_r = '0;
      sum_g = '0;
      sum_b = '0;
      count = '0;
      blends++;
    endfunction

    function void check_pixel(logic [11:0] x, logic [11:0] y, logic [31:0] colour);
      pixel_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: pixel with no blend outstanding: x=%0d y=%0d colour=%h",
                   $time, x, y, colour);
        return;
      end
      want = pending.pop_front();
      results++;
      if (want.x !== x || want.y !== y || want.colour !== colour) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: pixel mismatch: expected x=%0d y=%0d colour=%h, got x=%0d y=%0d colour=%h",
                   $time, want.x, want.y, want.colour, x, y, colour);
      end
    endfunction
  endclass

  logic        clk_i              = 1'b0;
  logic        rst_ni             = 1'b0;
  logic        start              = 1'b0;
  logic        busy;
  logic [11:0] pos_x_i            = '0;
  logic [11:0] pos_y_i            = '0;
  logic [31:0] fore_color_i       = '0;
  logic [8:0]  brightness_i       = '0;
  logic [2:0]  direction_i        = '0;
  logic        neighbor_enabled_i = 1'b0;
  logic [31:0] neighbor_value_i   = '0;
  logic [11:0] out_x_o;
  logic [11:0] out_y_o;
  logic [31:0] blended_color_o;
  logic        done_o;
  logic        cfg_valid_i        = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i        = '0;
  logic [31:0] cfg_data_i         = '0;

  blend_scoreboard sb = new();
  int              idle_pct = 0;
  bit              gaps_on = 1'b0;
  int              settings = 0;

  antialiased_pixel_blend i_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_pixel(out_x_o, out_y_o, blended_color_o);
      if (start && !busy)
        sb.take_neighbour(pos_x_i, pos_y_i, fore_color_i, brightness_i, direction_i,
                          neighbor_enabled_i, neighbor_value_i);
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
    end
  end

  function automatic logic [26:0] make_format(int rsh, int rsz, int gsh, int gsz,
                                              int bsh, int bsz);
    logic [26:0] f;
    f = '0;
    f[RShiftLsb +: ShiftW] = ShiftW'(rsh);
    f[RSizeLsb +: SizeW]   = SizeW'(rsz);
    f[GShiftLsb +: ShiftW] = ShiftW'(gsh);
    f[GSizeLsb +: SizeW]   = SizeW'(gsz);
    f[BShiftLsb +: ShiftW] = ShiftW'(bsh);
    f[BSizeLsb +: SizeW]   = SizeW'(bsz);
    return f;
  endfunction

  function automatic logic [11:0] pick_coord(input logic [12:0] limit);
    int hi;
    hi = (limit == '0 || limit > 13'd4096) ? 4095 : int'(limit) - 1;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 12'hFFF;
      2:       return 12'(hi);
      3:       return 12'($urandom_range(0, 4095));
      default: return 12'($urandom_range(0, hi));
    endcase
  endfunction

  function automatic logic [8:0] pick_brightness();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return BrightFull;
      2:       return 9'($urandom_range(257, 511));
      default: return 9'($urandom_range(0, 256));
    endcase
  endfunction

  task automatic write_cfg(input cfg_reg_e idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic program_regs(input logic [26:0] pf, input logic [12:0] w,
                              input logic [12:0] h, input logic [31:0] bg);
    write_cfg(CfgPixelFormat, 32'(pf));
    write_cfg(CfgScreenWidth, 32'(w));
    write_cfg(CfgScreenHeight, 32'(h));
    write_cfg(CfgBackground, bg);
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  task automatic send_item(input logic [11:0] x, input logic [11:0] y,
                           input logic [31:0] fg, input logic [8:0] b,
                           input logic [2:0] dir, input logic en,
                           input logic [31:0] nb);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    start              <= 1'b1;
    pos_x_i            <= x;
    pos_y_i            <= y;
    fore_color_i       <= fg;
    brightness_i       <= b;
    direction_i        <= dir;
    neighbor_enabled_i <= en;
    neighbor_value_i   <= nb;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic send_blend(output int n);
    logic [11:0] x;
    logic [11:0] y;
    logic [31:0] fg;
    logic [8:0]  b;
    bit          tidy;
    tidy = $urandom_range(0, 3) != 0;
    n = tidy ? 8 : $urandom_range(1, 12);
    idle_pct = (!gaps_on || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
    x  = pick_coord(sb.width);
    y  = pick_coord(sb.height);
    fg = $urandom;
    b  = pick_brightness();
    for (int i = 0; i < n; i++) begin
      if (!tidy) begin
        x  = pick_coord(sb.width);
        y  = pick_coord(sb.height);
        fg = $urandom;
        b  = pick_brightness();
      end
      send_item(x, y, fg, b, tidy ? 3'(i) : 3'($urandom_range(0, 7)),
                $urandom_range(0, 4) != 0,
                ($urandom_range(0, 5) == 0) ? fg : 32'($urandom));
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic run_phase(input int budget);
    int sent;
    int n;
    sent = 0;
    while (sent < budget) begin
      send_blend(n);
      sent += n;
    end
    settle();
  endtask

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    program_regs(make_format(16, 8, 8, 8, 0, 8), 13'd640, 13'd480, 32'h00A0B0C0);

    send_item(12'd5, 12'd5, 32'h00FF8000, 9'd0, DirE, 1'b1, 32'hFFFFFFFF);
    send_item(12'd5, 12'd5, 32'h00FF8000, 9'd0, DirSE, 1'b1, 32'h00000000);
    send_item(12'd5, 12'd5, 32'h00FF8000, 9'd0, DirS, 1'b1, 32'h00123456);
    send_item(12'd5, 12'd5, 32'h00FF8000, 9'd0, DirSW, 1'b1, 32'h00FF8000);
    send_item(12'd5, 12'd5, 32'h00FF8000, 9'd0, DirW, 1'b1, 32'h00010203);
    send_item(12'd5, 12'd5, 32'h00FF8000, 9'd0, DirNW, 1'b1, 32'h7F7F7F7F);
    send_item(12'd5, 12'd5, 32'h00FF8000, 9'd0, DirN, 1'b0, 32'h55555555);
    send_item(12'd5, 12'd5, 32'h00FF8000, 9'd0, DirNE, 1'b1, 32'h80808080);
    // corner pixel, nothing counts: fall back to the background
    send_item(12'd0, 12'd0, 32'hFFFFFFFF, 9'd511, DirNE, 1'b1, 32'h11111111);
    // more than eight neighbours, all from the same direction
    for (int i = 0; i < 10; i++)
      send_item(12'd1, 12'd1, 32'h0, BrightFull, DirS, 1'b1, 32'h01010101 * (i + 1));
    send_item(12'd638, 12'd1, 32'h0, BrightFull, DirNE, 1'b1, 32'hFFFFFFFF);
    send_item(12'd639, 12'd479, 32'h00C0FFEE, 9'd128, DirE, 1'b1, 32'h0);
    send_item(12'd639, 12'd479, 32'h00C0FFEE, 9'd128, DirSE, 1'b1, 32'h0);
    send_item(12'd639, 12'd479, 32'h00C0FFEE, 9'd128, DirNE, 1'b1, 32'h00C0FFEE);
    settle();

    gaps_on = 1'b1;
    program_regs(make_format(0, 8, 8, 8, 16, 8), 13'd4096, 13'd4096, 32'hFFFFFFFF);
    run_phase(150);
    program_regs(make_format(11, 5, 5, 6, 0, 5), 13'd1, 13'd1, $urandom);
    run_phase(120);
    program_regs(27'd0, 13'd0, 13'd0, $urandom);
    run_phase(90);
    program_regs(27'h7FFFFFF, 13'h1FFF, 13'h1FFF, $urandom);
    run_phase(120);
    program_regs(27'($urandom), 13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
                 $urandom);
    run_phase(150);
    program_regs(make_format(24, 8, 16, 8, 8, 8), 13'd2, 13'd3, 32'h0);
    run_phase(120);
    program_regs(27'($urandom), 13'd640, 13'd480, $urandom);
    run_phase(130);
    // drop idling for the closing stretch
    gaps_on = 1'b0;
    program_regs(PixelFormatRst, ScreenWidthRst, ScreenHeightRst, BackgroundRst);
    run_phase(150);

    $display("Ran %0d neighbour items forming %0d blends across %0d register settings",
             sb.items, sb.blends, settings);
    $display("Checked %0d blended pixels: %0d mismatches, %0d still outstanding",
             sb.results, sb.mismatches, sb.pending.size());
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
